### rtl/core/tibs_pkg.sv
// ----------------------------------------------------------------------------
// Triple intersection best scorer: shared types and constants
// Field widths, command and register codes, and the transaction structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tibs_pkg;

   localparam int GENE_W     = 10;
   localparam int SIDX_W     = 10;
   localparam int COUNT_W    = 11;
   localparam int ALPHA_W    = 9;
   localparam int SCORE_W    = 20;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      CMD_LOAD       = 2'd0,
      CMD_CLEAR_BEST = 2'd1,
      CMD_SCORE      = 2'd2,
      CMD_COMMIT     = 2'd3
   } tibs_cmd_type;

   localparam logic [1:0] REG_TUMOR_COUNT  = 2'd0;
   localparam logic [1:0] REG_NORMAL_COUNT = 2'd1;
   localparam logic [1:0] REG_ALPHA_WEIGHT = 2'd2;

   typedef struct packed {
      tibs_cmd_type       command;
      logic [GENE_W-1:0]  load_gene;
      logic [SIDX_W-1:0]  load_sample;
      logic [GENE_W-1:0]  first_gene;
      logic [GENE_W-1:0]  second_gene;
      logic [GENE_W-1:0]  third_gene;
   } tibs_req_type;

   typedef struct packed {
      logic               best_valid;
      logic [GENE_W-1:0]  best_first;
      logic [GENE_W-1:0]  best_second;
      logic [GENE_W-1:0]  best_third;
      logic [SCORE_W-1:0] best_score;
      logic [SCORE_W-1:0] triple_score;
      logic [COUNT_W-1:0] covered_count;
   } tibs_rsp_type;

   typedef struct packed {
      logic wipe;
      logic restart;
      logic word_valid;
      logic commit;
   } tibs_tally_ctrl_type;

endpackage

`default_nettype wire

### rtl/core/triple_intersection_best_scorer.sv
// ----------------------------------------------------------------------------
// Triple intersection best scorer
// Gene-by-sample membership bitmap with triple scoring, best-triple tracking
// and a covered tumor bitmap, driven by one membership memory port.
// ----------------------------------------------------------------------------
//  port group  dir     handshake                        payload
//  req         in      req_valid / req_stall            tibs_req_type
//  rsp         out     rsp_valid / rsp_stall            tibs_rsp_type
//  csr         in/out  csr_psel, csr_penable, pready    32-bit registers
//
//  After reset a clearing pass zeroes all GENES*ROW_WORDS words of the
//  membership memory (16384 at the defaults); req_stall stays high throughout.
//  Load steps through divide, read, wait and write states; clear best goes
//  straight to the reply. Score and commit fetch the three rows through the
//  single memory read port, one word a cycle, before tallying.
//  One transaction is worked at a time; an untaken result holds the next
//  result back but not the next accept.
// ----------------------------------------------------------------------------
`default_nettype none

module triple_intersection_best_scorer
   import tibs_pkg::*;
#(
   parameter int GENES     = 1024,
   parameter int SAMPLES   = 1024,
   parameter int WORD_BITS = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  tibs_req_type            req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output tibs_rsp_type            rsp_data,
   input  wire                     csr_psel,
   input  wire                     csr_penable,
   input  wire                     csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   localparam int ROW_WORDS   = (SAMPLES + WORD_BITS - 1) / WORD_BITS;
   localparam int MEM_DEPTH   = GENES * ROW_WORDS;
   localparam int ADDR_W      = $clog2(MEM_DEPTH);
   localparam int WIDX_W      = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int SPAN_W      = $clog2(ROW_WORDS * WORD_BITS + 1);
   localparam int POS_W       = (SPAN_W > COUNT_W + 1) ? SPAN_W : COUNT_W + 1;
   localparam int TP_W        = $clog2(SAMPLES + 1);
   localparam int PROD_W      = ALPHA_W + TP_W;
   localparam int SUM_W       = ((PROD_W > COUNT_W + 8) ? PROD_W : COUNT_W + 8) + 1;
   localparam int SUM_A_W     = ADDR_W + GENE_W + 1;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP       = (1 << RECIP_SHIFT) / WORD_BITS;
   localparam int LD_W        = 16;
   localparam logic [1:0] PH_LAST = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_DIV,
      ST_LOAD_RD,
      ST_LOAD_WAIT,
      ST_LOAD_WR,
      ST_RUN_SETUP,
      ST_RUN_ISSUE,
      ST_RUN_DRAIN,
      ST_SCORE_MUL,
      ST_SCORE_SUM,
      ST_REPLY
   } state_type;

   logic [WORD_BITS-1:0] member_mem [MEM_DEPTH];

   state_type            state_ff;
   logic [ADDR_W-1:0]    clr_ff;
   logic [WORD_BITS-1:0] rd_q_ff;

   logic [COUNT_W-1:0]   tumor_ff;
   logic [COUNT_W-1:0]   normal_ff;
   logic [ALPHA_W-1:0]   alpha_ff;

   logic [GENE_W-1:0]    ld_gene_ff;
   logic [SIDX_W-1:0]    ld_sample_ff;
   logic [SIDX_W-1:0]    ld_q0_ff;
   logic [ADDR_W-1:0]    ld_row_ff;
   logic [ADDR_W-1:0]    ld_addr_ff;
   logic [BIT_W-1:0]     ld_bit_ff;

   logic                 job_commit_ff;
   logic [GENE_W-1:0]    job_gene_ff [3];
   logic [ADDR_W-1:0]    base_ff [3];
   logic                 gok_ff [3];

   logic [WIDX_W-1:0]    is_word_ff;
   logic [1:0]           is_phase_ff;
   logic [POS_W-1:0]     is_base_ff;

   logic                 s1_valid_ff;
   logic [1:0]           s1_phase_ff;
   logic [WIDX_W-1:0]    s1_word_ff;
   logic [POS_W-1:0]     s1_base_ff;
   logic                 s1_ok_ff;
   logic [WORD_BITS-1:0] acc_ff;

   logic [PROD_W-1:0]    prod_ff;
   logic [COUNT_W-1:0]   tn_ff;

   logic                 best_valid_ff;
   logic [GENE_W-1:0]    best_gene_ff [3];
   logic [SCORE_W-1:0]   best_score_ff;
   logic [SCORE_W-1:0]   this_score_ff;
   logic [COUNT_W-1:0]   covered_total_ff;

   logic                 rsp_valid_ff;
   tibs_rsp_type         rsp_data_ff;

   logic                 accept;
   logic                 csr_write;
   logic [ADDR_W-1:0]    mem_addr;
   logic                 mem_we;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [ADDR_W-1:0]    iss_base;
   logic                 iss_ok;
   logic [ADDR_W-1:0]    iss_addr;
   logic [WORD_BITS-1:0] acc_word;
   logic [LD_W-1:0]      ld_prod;
   logic [LD_W-1:0]      ld_rem;
   logic                 ld_fix;
   logic [SIDX_W-1:0]    ld_q;
   logic [LD_W-1:0]      ld_r;
   logic                 ld_ok;
   logic [COUNT_W-1:0]   fp_clamp;
   logic [SUM_W-1:0]     score_sum;
   logic [SCORE_W-1:0]   score_sat;
   logic [COUNT_W-1:0]   cover_sat;

   tibs_tally_ctrl_type  tally_ctrl;
   logic [WIDX_W-1:0]    tally_idx;
   logic [TP_W-1:0]      tp_sum;
   logic [TP_W-1:0]      fp_sum;
   logic [TP_W-1:0]      cov_sum;
   logic                 tally_busy;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         REG_TUMOR_COUNT:  csr_prdata = CSR_DATA_W'(tumor_ff);
         REG_NORMAL_COUNT: csr_prdata = CSR_DATA_W'(normal_ff);
         REG_ALPHA_WEIGHT: csr_prdata = CSR_DATA_W'(alpha_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tumor_ff  <= COUNT_W'(512);
         normal_ff <= COUNT_W'(512);
         alpha_ff  <= ALPHA_W'(128);
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_TUMOR_COUNT:  tumor_ff  <= csr_pwdata[COUNT_W-1:0];
            REG_NORMAL_COUNT: normal_ff <= csr_pwdata[COUNT_W-1:0];
            REG_ALPHA_WEIGHT: alpha_ff  <= csr_pwdata[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath
   always_comb begin
      ld_ok = (32'(req_data.load_gene) < GENES) && (32'(req_data.load_sample) < SAMPLES);

      ld_prod = LD_W'(ld_q0_ff) * LD_W'(WORD_BITS);
      ld_rem  = LD_W'(ld_sample_ff) - ld_prod;
      ld_fix  = (ld_rem >= LD_W'(WORD_BITS));
      ld_q    = ld_fix ? ld_q0_ff + SIDX_W'(1) : ld_q0_ff;
      ld_r    = ld_fix ? ld_rem - LD_W'(WORD_BITS) : ld_rem;

      case (is_phase_ff)
         2'd0:    begin iss_base = base_ff[0]; iss_ok = gok_ff[0]; end
         2'd1:    begin iss_base = base_ff[1]; iss_ok = gok_ff[1]; end
         default: begin iss_base = base_ff[2]; iss_ok = gok_ff[2]; end
      endcase
      iss_addr = ADDR_W'(SUM_A_W'(iss_base) + SUM_A_W'(is_word_ff));

      mem_we    = 1'b0;
      mem_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_addr = clr_ff;
            mem_we   = 1'b1;
         end
         ST_LOAD_WAIT: mem_addr = ld_addr_ff;
         ST_LOAD_WR: begin
            mem_addr  = ld_addr_ff;
            mem_we    = 1'b1;
            mem_wdata = rd_q_ff | (WORD_BITS'(1) << ld_bit_ff);
         end
         default: mem_addr = iss_addr;
      endcase

      acc_word = s1_ok_ff ? rd_q_ff : '0;

      tally_ctrl.wipe       = (state_ff == ST_CLEAR) && (32'(clr_ff) < ROW_WORDS);
      tally_ctrl.restart    = (state_ff == ST_RUN_SETUP);
      tally_ctrl.word_valid = s1_valid_ff && (s1_phase_ff == PH_LAST);
      tally_ctrl.commit     = job_commit_ff;
      tally_idx = (state_ff == ST_CLEAR) ? clr_ff[WIDX_W-1:0] : s1_word_ff;

      fp_clamp  = (32'(fp_sum) > 32'(normal_ff)) ? normal_ff : COUNT_W'(fp_sum);
      score_sum = SUM_W'(prod_ff) + (SUM_W'(tn_ff) << 8);
      score_sat = (score_sum > SUM_W'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(score_sum);
      cover_sat = (32'(cov_sum) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(cov_sum);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         member_mem[mem_addr] <= mem_wdata;
      end
      rd_q_ff <= member_mem[mem_addr];
   end

   tibs_tally #(
      .WORD_BITS (WORD_BITS),
      .ROW_WORDS (ROW_WORDS),
      .WIDX_W    (WIDX_W),
      .POS_W     (POS_W),
      .TP_W      (TP_W)
   ) u_tally (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (tally_ctrl),
      .word_idx    (tally_idx),
      .word_base   (s1_base_ff),
      .common_word (acc_ff & acc_word),
      .tumor_count (tumor_ff),
      .normal_end  ((COUNT_W + 1)'(tumor_ff) + (COUNT_W + 1)'(normal_ff)),
      .tp_sum      (tp_sum),
      .fp_sum      (fp_sum),
      .cov_sum     (cov_sum),
      .busy        (tally_busy)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_ff           <= '0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         best_valid_ff    <= 1'b0;
         best_gene_ff[0]  <= '0;
         best_gene_ff[1]  <= '0;
         best_gene_ff[2]  <= '0;
         best_score_ff    <= '0;
         this_score_ff    <= '0;
         covered_total_ff <= '0;
         job_commit_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= (state_ff == ST_RUN_ISSUE);
         if (state_ff == ST_RUN_ISSUE) begin
            s1_phase_ff <= is_phase_ff;
            s1_word_ff  <= is_word_ff;
            s1_base_ff  <= is_base_ff;
            s1_ok_ff    <= iss_ok;
         end
         if (s1_valid_ff) begin
            acc_ff <= (s1_phase_ff == 2'd0) ? acc_word : acc_ff & acc_word;
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_REPLY)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + ADDR_W'(1);
               if (clr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  this_score_ff <= '0;
                  case (req_data.command)
                     CMD_LOAD: begin
                        ld_gene_ff   <= req_data.load_gene;
                        ld_sample_ff <= req_data.load_sample;
                        state_ff     <= ld_ok ? ST_LOAD_DIV : ST_REPLY;
                     end
                     CMD_CLEAR_BEST: begin
                        best_valid_ff   <= 1'b0;
                        best_gene_ff[0] <= '0;
                        best_gene_ff[1] <= '0;
                        best_gene_ff[2] <= '0;
                        best_score_ff   <= '0;
                        state_ff        <= ST_REPLY;
                     end
                     CMD_SCORE: begin
                        job_commit_ff  <= 1'b0;
                        job_gene_ff[0] <= req_data.first_gene;
                        job_gene_ff[1] <= req_data.second_gene;
                        job_gene_ff[2] <= req_data.third_gene;
                        state_ff       <= ST_RUN_SETUP;
                     end
                     CMD_COMMIT: begin
                        job_commit_ff  <= 1'b1;
                        job_gene_ff[0] <= best_gene_ff[0];
                        job_gene_ff[1] <= best_gene_ff[1];
                        job_gene_ff[2] <= best_gene_ff[2];
                        state_ff       <= best_valid_ff ? ST_RUN_SETUP : ST_REPLY;
                     end
                     default: state_ff <= ST_REPLY;
                  endcase
               end
            end
            ST_LOAD_DIV: begin
               ld_q0_ff  <= SIDX_W'((32'(ld_sample_ff) * 32'(RECIP)) >> RECIP_SHIFT);
               ld_row_ff <= ADDR_W'(SUM_A_W'(ld_gene_ff) * SUM_A_W'(ROW_WORDS));
               state_ff  <= ST_LOAD_RD;
            end
            ST_LOAD_RD: begin
               ld_addr_ff <= ADDR_W'(SUM_A_W'(ld_row_ff) + SUM_A_W'(ld_q));
               ld_bit_ff  <= ld_r[BIT_W-1:0];
               state_ff   <= ST_LOAD_WAIT;
            end
            ST_LOAD_WAIT: state_ff <= ST_LOAD_WR;
            ST_LOAD_WR:   state_ff <= ST_REPLY;
            ST_RUN_SETUP: begin
               for (int k = 0; k < 3; k++) begin
                  base_ff[k] <= ADDR_W'(SUM_A_W'(job_gene_ff[k]) * SUM_A_W'(ROW_WORDS));
                  gok_ff[k]  <= (32'(job_gene_ff[k]) < GENES);
               end
               is_word_ff  <= '0;
               is_phase_ff <= 2'd0;
               is_base_ff  <= '0;
               state_ff    <= ST_RUN_ISSUE;
            end
            ST_RUN_ISSUE: begin
               if (is_phase_ff == PH_LAST) begin
                  is_phase_ff <= 2'd0;
                  is_word_ff  <= is_word_ff + WIDX_W'(1);
                  is_base_ff  <= is_base_ff + POS_W'(WORD_BITS);
                  if (is_word_ff == WIDX_W'(ROW_WORDS - 1)) begin
                     state_ff <= ST_RUN_DRAIN;
                  end
               end else begin
                  is_phase_ff <= is_phase_ff + 2'd1;
               end
            end
            ST_RUN_DRAIN: begin
               if (!s1_valid_ff && !tally_busy) begin
                  if (job_commit_ff) begin
                     covered_total_ff <= cover_sat;
                     state_ff         <= ST_REPLY;
                  end else begin
                     state_ff <= ST_SCORE_MUL;
                  end
               end
            end
            ST_SCORE_MUL: begin
               prod_ff  <= PROD_W'(alpha_ff) * PROD_W'(tp_sum);
               tn_ff    <= normal_ff - fp_clamp;
               state_ff <= ST_SCORE_SUM;
            end
            ST_SCORE_SUM: begin
               this_score_ff <= score_sat;
               if (!best_valid_ff || (score_sat > best_score_ff)) begin
                  best_valid_ff   <= 1'b1;
                  best_gene_ff[0] <= job_gene_ff[0];
                  best_gene_ff[1] <= job_gene_ff[1];
                  best_gene_ff[2] <= job_gene_ff[2];
                  best_score_ff   <= score_sat;
               end
               state_ff <= ST_REPLY;
            end
            ST_REPLY: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_data_ff.best_valid      <= best_valid_ff;
                  rsp_data_ff.best_first      <= best_gene_ff[0];
                  rsp_data_ff.best_second     <= best_gene_ff[1];
                  rsp_data_ff.best_third      <= best_gene_ff[2];
                  rsp_data_ff.best_score      <= best_score_ff;
                  rsp_data_ff.triple_score    <= this_score_ff;
                  rsp_data_ff.covered_count   <= covered_total_ff;
                  state_ff                    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_rsp_from_reply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_REPLY))
      else $error("result raised outside the reply step");

   a_empty_best: assert property (@(posedge clock) disable iff (reset)
      !best_valid_ff |-> (best_score_ff == '0) && (best_gene_ff[0] == '0)
                         && (best_gene_ff[1] == '0) && (best_gene_ff[2] == '0))
      else $error("best triple not cleared while invalid");

   a_words_in_run: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (state_ff == ST_RUN_ISSUE) || (state_ff == ST_RUN_DRAIN))
      else $error("row word in flight outside a run");

   a_cover_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> covered_total_ff >= $past(covered_total_ff))
      else $error("covered count decreased");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted transaction not started");
`endif

endmodule

`default_nettype wire

### rtl/core/tibs_tally.sv
// ----------------------------------------------------------------------------
// Tally unit
// Masks each common word into tumor and normal spans, popcounts them and
// accumulates TP and FP, or merges tumor hits into the covered bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

module tibs_tally
   import tibs_pkg::*;
#(
   parameter int WORD_BITS = 64,
   parameter int ROW_WORDS = 16,
   parameter int WIDX_W    = 4,
   parameter int POS_W     = 12,
   parameter int TP_W      = 11
) (
   input  wire                       clock,
   input  wire                       reset,
   input  tibs_tally_ctrl_type       ctrl,
   input  wire  [WIDX_W-1:0]         word_idx,
   input  wire  [POS_W-1:0]          word_base,
   input  wire  [WORD_BITS-1:0]      common_word,
   input  wire  [COUNT_W-1:0]        tumor_count,
   input  wire  [COUNT_W:0]          normal_end,
   output logic [TP_W-1:0]           tp_sum,
   output logic [TP_W-1:0]           fp_sum,
   output logic [TP_W-1:0]           cov_sum,
   output logic                      busy
);

   function automatic logic [WORD_BITS-1:0] span_mask(input logic [POS_W-1:0] lo,
                                                      input logic [POS_W-1:0] hi,
                                                      input logic [POS_W-1:0] base);
      logic [POS_W-1:0]     s;
      logic [POS_W-1:0]     e;
      logic [WORD_BITS-1:0] m;
      s = (lo > base) ? lo - base : '0;
      e = (hi > base) ? hi - base : '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         m[i] = (POS_W'(i) >= s) && (POS_W'(i) < e);
      end
      return m;
   endfunction

   function automatic logic [6:0] popcount64(input logic [63:0] x);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
      logic [63:0] f;
      logic [63:0] g;
      a = x - ((x >> 1) & 64'h5555_5555_5555_5555);
      b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
      c = (b + (b >> 4)) & 64'h0f0f_0f0f_0f0f_0f0f;
      d = c + (c >> 8);
      f = d + (d >> 16);
      g = f + (f >> 32);
      return g[6:0];
   endfunction

   logic [WORD_BITS-1:0] cov_mem [ROW_WORDS];

   logic                 a_valid_ff;
   logic                 a_commit_ff;
   logic [WIDX_W-1:0]    a_idx_ff;
   logic [WORD_BITS-1:0] a_tword_ff;
   logic [WORD_BITS-1:0] a_fword_ff;
   logic [WORD_BITS-1:0] cov_q_ff;
   logic [TP_W-1:0]      tp_sum_ff;
   logic [TP_W-1:0]      fp_sum_ff;
   logic [TP_W-1:0]      cov_sum_ff;

   logic [WORD_BITS-1:0] tmask;
   logic [WORD_BITS-1:0] fmask;
   logic [WORD_BITS-1:0] cov_new;
   logic [6:0]           pop_t;
   logic [6:0]           pop_f;
   logic [6:0]           pop_c;

   always_comb begin
      tmask   = span_mask('0, POS_W'(tumor_count), word_base);
      fmask   = span_mask(POS_W'(tumor_count), POS_W'(normal_end), word_base);
      cov_new = cov_q_ff | a_tword_ff;
      pop_t   = popcount64(64'(a_tword_ff));
      pop_f   = popcount64(64'(a_fword_ff));
      pop_c   = popcount64(64'(cov_new));
   end

   always_ff @(posedge clock) begin
      if (ctrl.wipe) begin
         cov_mem[word_idx] <= '0;
      end else if (a_valid_ff && a_commit_ff) begin
         cov_mem[a_idx_ff] <= cov_new;
      end
      cov_q_ff <= cov_mem[word_idx];
      if (ctrl.word_valid) begin
         a_commit_ff <= ctrl.commit;
         a_idx_ff    <= word_idx;
         a_tword_ff  <= common_word & tmask;
         a_fword_ff  <= common_word & fmask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         tp_sum_ff  <= '0;
         fp_sum_ff  <= '0;
         cov_sum_ff <= '0;
      end else begin
         a_valid_ff <= ctrl.word_valid;
         if (ctrl.restart) begin
            tp_sum_ff  <= '0;
            fp_sum_ff  <= '0;
            cov_sum_ff <= '0;
         end else if (a_valid_ff) begin
            if (a_commit_ff) begin
               cov_sum_ff <= cov_sum_ff + TP_W'(pop_c);
            end else begin
               tp_sum_ff <= tp_sum_ff + TP_W'(pop_t);
               fp_sum_ff <= fp_sum_ff + TP_W'(pop_f);
            end
         end
      end
   end

   assign tp_sum  = tp_sum_ff;
   assign fp_sum  = fp_sum_ff;
   assign cov_sum = cov_sum_ff;
   assign busy    = a_valid_ff;

endmodule

`default_nettype wire
